// ===== rtl/periodic_frame_group_scheduler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame group scheduler
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_FRAME_GROUP_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_FRAME_GROUP_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define PFGS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pfgs: check failed");
// antecedent in one cycle implies consequent in the next
`define PFGS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) ante |=> cons) \
        else $error("pfgs: sequence check failed");
`else
`define PFGS_ASSERT(lbl, prop)
`define PFGS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/pfgs_pkg.sv =====
// ----------------------------------------------------------------------------
// pfgs_pkg
// Shared types and constants of the frame group scheduler.
// ----------------------------------------------------------------------------
package pfgs_pkg;

    localparam int DEF_NUM_GROUPS = 16;
    localparam int DEF_MAX_FRAMES = 8;
    localparam int ID_W           = 29;
    localparam int TIME_W         = 32;
    localparam int MAX_OUT        = 16;   // frames emitted per tick at most
    localparam int DIV_STEPS      = 32;   // one quotient bit per cycle

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_QUERY  = 2'd3
    } pfgs_kind_t;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_APPENDED = 2'd0;
    localparam logic [1:0] ST_REPLACED = 2'd1;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // command handed from front to back (ids and count travel alongside)
    typedef struct packed {
        pfgs_kind_t          kind;
        logic [TIME_W-1:0]   value;   // now for tick, period for add
        logic                over;    // staged sequence overflowed
    } pfgs_cmd_t;

    typedef struct packed {
        pfgs_kind_t          kind;
        logic [ID_W-1:0]     send_id;
        logic [3:0]          slot;
        logic [2:0]          pos;
        logic [1:0]          status;
        logic                last;
    } pfgs_res_t;

endpackage

// ===== rtl/periodic_frame_group_scheduler_unit.sv =====
// An id item not marked last is only staged in the front and causes no result.
// Tick: each group is read and checked (S_T_RD, S_T_CHK), a due one updated (S_T_UPD).
// Add: groups are compared, rows moved up, then the period is divided by the frame count.
// The back takes one command at a time, popping the next only in S_IDLE; the walk over
// the row memory, one id row at a time, and the bit-serial divider set its pace.
// Reset (aresetn low, synchronous): table empty, staging cleared; no clearing pass.
// ----------------------------------------------------------------------------
// periodic_frame_group_scheduler_unit
// Periodic frame group scheduler: front stages ids, back walks the table.
// ----------------------------------------------------------------------------
module periodic_frame_group_scheduler_unit #(
    parameter int NUM_GROUPS = pfgs_pkg::DEF_NUM_GROUPS,
    parameter int MAX_FRAMES = pfgs_pkg::DEF_MAX_FRAMES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // frame_id[28:0], period_ms[60:29], now_ms[92:61]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        s_tlast,   // last
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // send_id[28:0], group_slot[32:29],
                                   // frame_pos[35:33], status[37:36]
    output logic [1:0]  m_tuser,   // result_kind[1:0]
    output logic        m_tlast    // final_res
);
    import pfgs_pkg::*;

`include "periodic_frame_group_scheduler_unit_assert.svh"

    localparam int CW    = $clog2(MAX_FRAMES + 1);
    localparam int ROW_W = MAX_FRAMES * ID_W;
    localparam int CMD_W = $bits(pfgs_cmd_t);
    localparam int Q_W   = ROW_W + CW + CMD_W;

    // front -> queue
    logic             q_push;
    logic             q_full;
    pfgs_cmd_t        f_cmd;
    logic [CW-1:0]    f_cnt;
    logic [ROW_W-1:0] f_ids;
    // queue -> back
    logic             q_pop;
    logic             q_empty;
    logic [Q_W-1:0]   q_data;
    pfgs_cmd_t        b_cmd;
    logic [CW-1:0]    b_cnt;
    logic [ROW_W-1:0] b_ids;
    pfgs_res_t        res;

    // front: classify the item, stage ids until the one marked last
    pfgs_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .kind      (pfgs_kind_t'(s_tuser)),
        .frame_id  (s_tdata[28:0]),
        .last      (s_tlast),
        .period_ms (s_tdata[60:29]),
        .now_ms    (s_tdata[92:61]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (f_cmd),
        .q_cnt     (f_cnt),
        .q_ids     (f_ids)
    );

    // short command queue so front and back stall independently
    pfgs_fifo #(
        .DATA_W (Q_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_ids, f_cnt, f_cmd}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    assign b_cmd = pfgs_cmd_t'(q_data[CMD_W-1:0]);
    assign b_cnt = q_data[CMD_W +: CW];
    assign b_ids = q_data[CMD_W+CW +: ROW_W];

    // back: table, tick walk, add / remove / query sequencer
    pfgs_back #(
        .NUM_GROUPS (NUM_GROUPS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_cmd     (b_cmd),
        .q_cnt     (b_cnt),
        .q_ids     (b_ids),
        .m_tready  (m_tready),
        .res_valid (m_tvalid),
        .res       (res)
    );

    assign m_tdata = {2'b00, res.status, res.pos, res.slot, res.send_id};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    // queue is never written full nor read empty; commands only from accepted items
    `PFGS_ASSERT(a_push_not_full, q_push |-> !q_full)
    `PFGS_ASSERT(a_pop_not_empty, q_pop |-> !q_empty)
    `PFGS_ASSERT(a_push_on_accept, q_push |-> (s_tvalid && s_tready))
    `PFGS_ASSERT_NEXT(a_full_holds, q_full && !q_pop, q_full)

endmodule

// ===== rtl/pfgs_fifo.sv =====
// ----------------------------------------------------------------------------
// pfgs_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module pfgs_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/pfgs_front.sv =====
// ----------------------------------------------------------------------------
// pfgs_front
// Accepts items, stages id sequences and queues complete commands.
// ----------------------------------------------------------------------------
module pfgs_front #(
    parameter int MAX_FRAMES = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  pfgs_pkg::pfgs_kind_t                 kind,
    input  logic [pfgs_pkg::ID_W-1:0]            frame_id,
    input  logic                                 last,
    input  logic [pfgs_pkg::TIME_W-1:0]          period_ms,
    input  logic [pfgs_pkg::TIME_W-1:0]          now_ms,
    input  logic                                 q_full,
    output logic                                 q_push,
    output pfgs_pkg::pfgs_cmd_t                  q_cmd,
    output logic [$clog2(MAX_FRAMES+1)-1:0]      q_cnt,
    output logic [MAX_FRAMES*pfgs_pkg::ID_W-1:0] q_ids
);
    import pfgs_pkg::*;

    localparam int CW    = $clog2(MAX_FRAMES + 1);
    localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int ROW_W = MAX_FRAMES * ID_W;

    logic [ROW_W-1:0] stage_ids_reg, stage_ids_next;
    logic [CW-1:0]    stage_cnt_reg, stage_cnt_next;
    logic             stage_over_reg, stage_over_next;
    logic [ROW_W-1:0] stg_ids;
    logic [CW-1:0]    stg_cnt;
    logic             stg_over;
    logic             accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    always_comb begin
        stg_ids  = stage_ids_reg;
        stg_cnt  = stage_cnt_reg;
        stg_over = stage_over_reg;
        if (stage_cnt_reg < CW'(MAX_FRAMES)) begin
            stg_ids[stage_cnt_reg[FW-1:0]*ID_W +: ID_W] = frame_id;
            stg_cnt = stage_cnt_reg + CW'(1);
        end else begin
            stg_over = 1'b1;
        end

        stage_ids_next  = stage_ids_reg;
        stage_cnt_next  = stage_cnt_reg;
        stage_over_next = stage_over_reg;
        q_push          = 1'b0;
        q_cmd.kind      = kind;
        q_cmd.value     = now_ms;
        q_cmd.over      = 1'b0;
        q_cnt           = stg_cnt;
        q_ids           = stg_ids;
        if (accept) begin
            if (kind == KIND_TICK) begin
                q_push = 1'b1;
            end else begin
                stage_ids_next = stg_ids;
                if (last) begin
                    q_push          = 1'b1;
                    q_cmd.value     = period_ms;
                    q_cmd.over      = stg_over;
                    stage_cnt_next  = '0;
                    stage_over_next = 1'b0;
                end else begin
                    stage_cnt_next  = stg_cnt;
                    stage_over_next = stg_over;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_cnt_reg  <= '0;
            stage_over_reg <= 1'b0;
        end else begin
            stage_cnt_reg  <= stage_cnt_next;
            stage_over_reg <= stage_over_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_ids_reg <= stage_ids_next;
    end

endmodule

// ===== rtl/pfgs_div.sv =====
// ----------------------------------------------------------------------------
// pfgs_div
// Restoring divider, period by frame count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfgs_div #(
    parameter int CW = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pfgs_pkg::TIME_W-1:0] dividend,
    input  logic [CW-1:0]               divisor,
    output logic                        done,
    output logic [pfgs_pkg::TIME_W-1:0] quot,
    output logic [CW-1:0]               rem
);
    import pfgs_pkg::*;

    localparam int SW = $clog2(DIV_STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [SW-1:0]     step_reg;
    logic [TIME_W-1:0] quo_reg;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     dvs_reg;
    logic [CW:0]       trial;
    logic              take;

    assign trial = {rem_reg, quo_reg[TIME_W-1]};
    assign take  = (trial >= {1'b0, dvs_reg});
    assign done  = done_reg;
    assign quot  = quo_reg;
    assign rem   = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[TIME_W-2:0], take};
            if (take) begin
                rem_reg <= CW'(trial - {1'b0, dvs_reg});
            end else begin
                rem_reg <= trial[CW-1:0];
            end
        end
    end

endmodule

// ===== rtl/pfgs_back.sv =====
// ----------------------------------------------------------------------------
// pfgs_back
// Group table, tick walk, match / erase / append sequencer, result register.
// ----------------------------------------------------------------------------
module pfgs_back #(
    parameter int NUM_GROUPS = 16,
    parameter int MAX_FRAMES = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_empty,
    output logic                                 q_pop,
    input  pfgs_pkg::pfgs_cmd_t                  q_cmd,
    input  logic [$clog2(MAX_FRAMES+1)-1:0]      q_cnt,
    input  logic [MAX_FRAMES*pfgs_pkg::ID_W-1:0] q_ids,
    input  logic                                 m_tready,
    output logic                                 res_valid,
    output pfgs_pkg::pfgs_res_t                  res
);
    import pfgs_pkg::*;

    localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int TW    = $clog2(NUM_GROUPS + 1);
    localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW    = $clog2(MAX_FRAMES + 1);
    localparam int NW    = $clog2(MAX_OUT + 1);
    localparam int ROW_W = MAX_FRAMES * ID_W;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_T_RD   = 13'b0000000000010,
        S_T_CHK  = 13'b0000000000100,
        S_T_UPD  = 13'b0000000001000,
        S_T_END  = 13'b0000000010000,
        S_M_RD   = 13'b0000000100000,
        S_M_CHK  = 13'b0000001000000,
        S_DECIDE = 13'b0000010000000,
        S_E_RD   = 13'b0000100000000,
        S_E_WR   = 13'b0001000000000,
        S_ADD    = 13'b0010000000000,
        S_DIV    = 13'b0100000000000,
        S_RES    = 13'b1000000000000
    } state_t;

    function automatic logic [TIME_W-1:0] mag32(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        if (d[TIME_W-1]) begin
            d = ~d + TIME_W'(1);
        end
        return d;
    endfunction

    state_t            state_reg;
    pfgs_cmd_t         cmd_reg;
    logic [CW-1:0]     cmd_cnt_reg;
    logic [ROW_W-1:0]  cmd_ids_reg;
    logic [TW-1:0]     total_reg;
    logic [TW-1:0]     g_reg;
    logic [TW-1:0]     j_reg;
    logic [NW-1:0]     n_reg;
    logic              found_reg;
    logic [GW-1:0]     m_reg;
    logic [GW-1:0]     slot_reg;
    logic [1:0]        st_reg;
    logic [TIME_W-1:0] per_reg;
    logic [TIME_W-1:0] cur_reg;
    logic              pend_valid_reg;
    pfgs_res_t         pend_reg;
    logic              out_valid_reg;
    pfgs_res_t         out_reg;

    // per-group fields
    logic [CW-1:0]     grp_cnt_reg   [NUM_GROUPS];
    logic [TIME_W-1:0] grp_base_reg  [NUM_GROUPS];   // period / count
    logic [TIME_W-1:0] grp_last_reg  [NUM_GROUPS];   // base + remainder
    logic [FW-1:0]     grp_pos_reg   [NUM_GROUPS];
    logic [TIME_W-1:0] grp_stamp_reg [NUM_GROUPS];
    logic              grp_sent_reg  [NUM_GROUPS];

    // id rows, one row per group
    logic [ROW_W-1:0]  row_mem [NUM_GROUPS];
    logic [ROW_W-1:0]  row_q;
    logic              rd_en;
    logic [GW-1:0]     rd_addr;
    logic              wr_en;
    logic [GW-1:0]     wr_addr;
    logic [ROW_W-1:0]  wr_data;

    logic [GW-1:0]     gi;
    logic [GW-1:0]     ti;
    logic [TW-1:0]     jp;
    logic [CW:0]       pos_inc;
    logic [CW:0]       cnt_ext;
    logic [FW-1:0]     npos;
    logic [TIME_W-1:0] cur_per;
    logic [TIME_W-1:0] new_per;
    logic              due;
    logic              ids_eq;
    logic              out_free;
    logic              out_load;
    logic              div_start;
    logic              div_done;
    logic [TIME_W-1:0] div_q;
    logic [CW-1:0]     div_r;
    logic [31:0]       gi_w;
    logic [31:0]       slot_w;
    logic [31:0]       pos_w;

    assign gi       = g_reg[GW-1:0];
    assign ti       = total_reg[GW-1:0];
    assign jp       = j_reg + TW'(1);
    assign out_free = !out_valid_reg || m_tready;
    // output register takes a new item this cycle
    assign out_load = ((state_reg == S_T_CHK) && due && pend_valid_reg && out_free) ||
                      ((state_reg == S_T_END) && pend_valid_reg && out_free) ||
                      ((state_reg == S_RES) && out_free);
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign div_start = (state_reg == S_ADD) && (total_reg < TW'(NUM_GROUPS));
    assign gi_w     = 32'(gi);
    assign slot_w   = 32'(slot_reg);
    assign pos_w    = 32'(grp_pos_reg[gi]);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // slot period and cyclic advance of the walked group
    always_comb begin
        cnt_ext = (CW+1)'(grp_cnt_reg[gi]);
        pos_inc = (CW+1)'(grp_pos_reg[gi]) + (CW+1)'(1);
        cur_per = (pos_inc == cnt_ext) ? grp_last_reg[gi] : grp_base_reg[gi];
        due     = !grp_sent_reg[gi] ||
                  (mag32(cmd_reg.value, grp_stamp_reg[gi]) >= cur_per);
        npos    = (pos_inc >= cnt_ext) ? '0 : pos_inc[FW-1:0];
        new_per = (((CW+1)'(npos) + (CW+1)'(1)) == cnt_ext) ?
                  grp_last_reg[gi] : grp_base_reg[gi];
    end

    always_comb begin
        ids_eq = (grp_cnt_reg[gi] == cmd_cnt_reg);
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if ((CW'(i) < cmd_cnt_reg) &&
                (row_q[i*ID_W +: ID_W] != cmd_ids_reg[i*ID_W +: ID_W])) begin
                ids_eq = 1'b0;
            end
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = gi;
        wr_en   = 1'b0;
        wr_addr = j_reg[GW-1:0];
        wr_data = row_q;
        unique case (state_reg)
            S_T_RD, S_M_RD: begin
                rd_en = (g_reg < total_reg);
            end
            S_E_RD: begin
                rd_en   = (jp < total_reg);
                rd_addr = jp[GW-1:0];
            end
            S_E_WR: begin
                wr_en = 1'b1;
            end
            S_DIV: begin
                wr_en   = div_done;
                wr_addr = ti;
                wr_data = cmd_ids_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            row_q <= row_mem[rd_addr];
        end
        if (wr_en) begin
            row_mem[wr_addr] <= wr_data;
        end
    end

    pfgs_div #(
        .CW (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cmd_reg.value),
        .divisor  (cmd_cnt_reg),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (m_tready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        cmd_reg     <= q_cmd;
                        cmd_cnt_reg <= q_cnt;
                        cmd_ids_reg <= q_ids;
                        g_reg       <= '0;
                        n_reg       <= '0;
                        found_reg   <= 1'b0;
                        slot_reg    <= '0;
                        if (q_cmd.kind == KIND_TICK) begin
                            state_reg <= S_T_RD;
                        end else if (q_cmd.over) begin
                            st_reg    <= (q_cmd.kind == KIND_ADD) ? ST_TOO_LONG : ST_NONE;
                            state_reg <= S_RES;
                        end else begin
                            state_reg <= S_M_RD;
                        end
                    end
                end
                S_T_RD: begin
                    state_reg <= (g_reg < total_reg) ? S_T_CHK : S_T_END;
                end
                S_T_CHK: begin
                    if (!due) begin
                        g_reg     <= g_reg + TW'(1);
                        state_reg <= S_T_RD;
                    end else if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            out_reg       <= pend_reg;
                            out_valid_reg <= 1'b1;
                        end
                        pend_valid_reg   <= 1'b1;
                        pend_reg.kind    <= KIND_TICK;
                        pend_reg.send_id <= row_q[grp_pos_reg[gi]*ID_W +: ID_W];
                        pend_reg.slot    <= gi_w[3:0];
                        pend_reg.pos     <= pos_w[2:0];
                        pend_reg.status  <= ST_NONE;
                        pend_reg.last    <= 1'b0;
                        n_reg            <= n_reg + NW'(1);
                        grp_pos_reg[gi]  <= npos;
                        per_reg          <= new_per;
                        cur_reg          <= grp_stamp_reg[gi] + new_per;
                        state_reg        <= S_T_UPD;
                    end
                end
                S_T_UPD: begin
                    // drift correction: keep the ideal stamp unless too far behind
                    grp_stamp_reg[gi] <= (mag32(cmd_reg.value, cur_reg) < per_reg) ?
                                         cur_reg : cmd_reg.value;
                    grp_sent_reg[gi]  <= 1'b1;
                    g_reg             <= g_reg + TW'(1);
                    state_reg <= (n_reg == NW'(MAX_OUT)) ? S_T_END : S_T_RD;
                end
                S_T_END: begin
                    if (!pend_valid_reg) begin
                        state_reg <= S_IDLE;
                    end else if (out_free) begin
                        out_reg        <= '{pend_reg.kind, pend_reg.send_id, pend_reg.slot,
                                            pend_reg.pos, pend_reg.status, 1'b1};
                        out_valid_reg  <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                S_M_RD: begin
                    state_reg <= (g_reg < total_reg) ? S_M_CHK : S_DECIDE;
                end
                S_M_CHK: begin
                    if (ids_eq) begin
                        found_reg <= 1'b1;
                        m_reg     <= gi;
                        state_reg <= S_DECIDE;
                    end else begin
                        g_reg     <= g_reg + TW'(1);
                        state_reg <= S_M_RD;
                    end
                end
                S_DECIDE: begin
                    j_reg <= TW'(m_reg);
                    case (cmd_reg.kind)
                        KIND_ADD: begin
                            st_reg    <= found_reg ? ST_REPLACED : ST_APPENDED;
                            state_reg <= found_reg ? S_E_RD : S_ADD;
                        end
                        KIND_REMOVE: begin
                            st_reg    <= found_reg ? ST_FOUND : ST_NONE;
                            slot_reg  <= found_reg ? m_reg : '0;
                            state_reg <= found_reg ? S_E_RD : S_RES;
                        end
                        default: begin
                            st_reg    <= found_reg ? ST_FOUND : ST_NONE;
                            slot_reg  <= found_reg ? m_reg : '0;
                            state_reg <= S_RES;
                        end
                    endcase
                end
                S_E_RD: begin
                    if (jp < total_reg) begin
                        grp_cnt_reg[j_reg[GW-1:0]]   <= grp_cnt_reg[jp[GW-1:0]];
                        grp_base_reg[j_reg[GW-1:0]]  <= grp_base_reg[jp[GW-1:0]];
                        grp_last_reg[j_reg[GW-1:0]]  <= grp_last_reg[jp[GW-1:0]];
                        grp_pos_reg[j_reg[GW-1:0]]   <= grp_pos_reg[jp[GW-1:0]];
                        grp_stamp_reg[j_reg[GW-1:0]] <= grp_stamp_reg[jp[GW-1:0]];
                        grp_sent_reg[j_reg[GW-1:0]]  <= grp_sent_reg[jp[GW-1:0]];
                        state_reg <= S_E_WR;
                    end else begin
                        total_reg <= total_reg - TW'(1);
                        state_reg <= (cmd_reg.kind == KIND_ADD) ? S_ADD : S_RES;
                    end
                end
                S_E_WR: begin
                    j_reg     <= jp;
                    state_reg <= S_E_RD;
                end
                S_ADD: begin
                    if (total_reg >= TW'(NUM_GROUPS)) begin
                        st_reg    <= ST_FULL;
                        slot_reg  <= '0;
                        state_reg <= S_RES;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        grp_cnt_reg[ti]   <= cmd_cnt_reg;
                        grp_base_reg[ti]  <= div_q;
                        grp_last_reg[ti]  <= div_q + TIME_W'(div_r);
                        grp_pos_reg[ti]   <= '0;
                        grp_stamp_reg[ti] <= '0;
                        grp_sent_reg[ti]  <= 1'b0;
                        slot_reg          <= ti;
                        total_reg         <= total_reg + TW'(1);
                        state_reg         <= S_RES;
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        out_reg.kind    <= cmd_reg.kind;
                        out_reg.send_id <= '0;
                        out_reg.slot    <= slot_w[3:0];
                        out_reg.pos     <= '0;
                        out_reg.status  <= st_reg;
                        out_reg.last    <= 1'b1;
                        out_valid_reg   <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
